// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL module duplicate_value_finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DVF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/dvf_pkg.sv =====
// Types and constants of the duplicate value finder.
package dvf_pkg;

  localparam int MaxElements = 256;
  localparam int AddrW       = $clog2(MaxElements);
  localparam int CntW        = AddrW + 1;
  localparam int ValInW      = 16;
  localparam int DupW        = 8;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StNone     = 2'd1,
    StRange    = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef struct packed {
    logic [ValInW-1:0] value;
    logic              is_last;
  } in_t;

  typedef struct packed {
    status_e         status;
    logic [DupW-1:0] duplicate;
  } out_t;

endpackage

// ===== rtl/core/duplicate_value_finder.sv =====
// Duplicate value finder: stores a list, then binary-searches the value range.
// Loading: requests are taken while in_stall_o is low; it is high from the last request
// until the result moves to the output register. After the last of N+1 requests: the error
// flags are judged, a range pass runs, up to ceil(log2 N)+1 counting passes follow, each led
// by a midpoint step, then a hand-over waits for any output stall; flag errors skip the passes.
// Reset clears the control state and counters; the element store is not cleared.
`include "assert_macros.svh"

module duplicate_value_finder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dvf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dvf_pkg::out_t out_data_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_EVAL,
    S_CHECK,
    S_MID,
    S_COUNT,
    S_RESULT
  } state_e;

  state_e                     state_q;
  logic [dvf_pkg::CntW-1:0]   cnt_q;
  logic                       bad_q;
  logic                       ovf_q;
  logic [dvf_pkg::CntW-1:0]   idx_q;
  logic                       rdv_q;
  logic                       big_q;
  logic [dvf_pkg::AddrW-1:0]  lo_q;
  logic [dvf_pkg::AddrW-1:0]  hi_q;
  logic [dvf_pkg::AddrW-1:0]  mid_q;
  logic [dvf_pkg::CntW-1:0]   rcnt_q;
  dvf_pkg::status_e           res_status_q;
  logic [dvf_pkg::DupW-1:0]   res_dup_q;
  logic                       out_valid_q;
  dvf_pkg::out_t              out_q;

  logic [dvf_pkg::AddrW-1:0]  store_mem [dvf_pkg::MaxElements];
  logic [dvf_pkg::AddrW-1:0]  rd_q;

  logic                       in_acc;
  logic                       full;
  logic                       val_bad;
  logic                       store_we;
  logic                       scanning;
  logic                       issue;
  logic                       pass_done;
  logic [dvf_pkg::CntW-1:0]   last_val;
  logic [dvf_pkg::AddrW:0]    mid_sum;
  logic [dvf_pkg::CntW-1:0]   half_w;
  logic                       in_half;
  logic                       out_free;

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign full        = (cnt_q == dvf_pkg::CntW'(dvf_pkg::MaxElements));
  assign val_bad     = (in_data_i.value == '0) ||
                       ({1'b0, in_data_i.value} >=
                        (dvf_pkg::ValInW + 1)'(dvf_pkg::MaxElements));
  assign store_we    = in_acc && !full;
  assign scanning    = (state_q == S_CHECK) || (state_q == S_COUNT);
  assign issue       = scanning && (idx_q != cnt_q);
  assign pass_done   = !issue && !rdv_q;
  assign last_val    = cnt_q - dvf_pkg::CntW'(1);
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign half_w      = dvf_pkg::CntW'(mid_q - lo_q) + dvf_pkg::CntW'(1);
  assign in_half     = (rd_q >= lo_q) && (rd_q <= mid_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Element store: one write port while loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[cnt_q[dvf_pkg::AddrW-1:0]] <= val_bad ? '0
                                              : in_data_i.value[dvf_pkg::AddrW-1:0];
    end
    rd_q <= store_mem[idx_q[dvf_pkg::AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
      idx_q        <= '0;
      rdv_q        <= 1'b0;
      big_q        <= 1'b0;
      lo_q         <= dvf_pkg::AddrW'(1);
      hi_q         <= '0;
      mid_q        <= '0;
      rcnt_q       <= '0;
      res_status_q <= dvf_pkg::StNone;
      res_dup_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      rdv_q <= issue;
      if (issue) begin
        idx_q <= idx_q + dvf_pkg::CntW'(1);
      end

      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              if (val_bad) begin
                bad_q <= 1'b1;
              end
              cnt_q <= cnt_q + dvf_pkg::CntW'(1);
            end
            if (in_data_i.is_last) begin
              state_q <= S_EVAL;
            end
          end
        end

        S_EVAL: begin
          res_dup_q <= '0;
          idx_q     <= '0;
          big_q     <= 1'b0;
          priority if (ovf_q) begin
            res_status_q <= dvf_pkg::StOverflow;
            state_q      <= S_RESULT;
          end else if (bad_q || (cnt_q < dvf_pkg::CntW'(2))) begin
            res_status_q <= dvf_pkg::StRange;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_CHECK;
          end
        end

        // Range pass: any stored value above N is out of range.
        S_CHECK: begin
          if (rdv_q && (dvf_pkg::CntW'(rd_q) > last_val)) begin
            big_q <= 1'b1;
          end
          if (pass_done) begin
            if (big_q) begin
              res_status_q <= dvf_pkg::StRange;
              state_q      <= S_RESULT;
            end else begin
              lo_q    <= dvf_pkg::AddrW'(1);
              hi_q    <= last_val[dvf_pkg::AddrW-1:0];
              state_q <= S_MID;
            end
          end
        end

        S_MID: begin
          mid_q   <= mid_sum[dvf_pkg::AddrW:1];
          idx_q   <= '0;
          rcnt_q  <= '0;
          state_q <= S_COUNT;
        end

        // Counting pass over the lower half [lo, mid].
        S_COUNT: begin
          if (rdv_q && in_half) begin
            rcnt_q <= rcnt_q + dvf_pkg::CntW'(1);
          end
          if (pass_done) begin
            if (lo_q == hi_q) begin
              if (rcnt_q > dvf_pkg::CntW'(1)) begin
                res_status_q <= dvf_pkg::StFound;
                res_dup_q    <= dvf_pkg::DupW'(lo_q);
              end else begin
                res_status_q <= dvf_pkg::StNone;
              end
              state_q <= S_RESULT;
            end else begin
              if (rcnt_q > half_w) begin
                hi_q <= mid_q;
              end else begin
                lo_q <= mid_q + dvf_pkg::AddrW'(1);
              end
              state_q <= S_MID;
            end
          end
        end

        // Hold until the output register is free, then start a new list.
        S_RESULT: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_q.status     <= res_status_q;
            out_q.duplicate  <= res_dup_q;
            cnt_q            <= '0;
            bad_q            <= 1'b0;
            ovf_q            <= 1'b0;
            state_q          <= S_LOAD;
          end
        end

        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  `DVF_ASSERT(a_out_from_result, $rose(out_valid_q) |-> $past(state_q == S_RESULT), "result without search end")
  `DVF_ASSERT_IMP(a_found_nonzero, out_valid_o && (out_data_o.status == dvf_pkg::StFound), out_data_o.duplicate != '0, "found duplicate is zero")
  `DVF_ASSERT_IMP(a_other_zero, out_valid_o && (out_data_o.status != dvf_pkg::StFound), out_data_o.duplicate == '0, "duplicate set without a find")
  `DVF_ASSERT_IMP(a_mid_in_range, state_q == S_COUNT, (lo_q <= mid_q) && (mid_q <= hi_q), "midpoint outside search range")

endmodule

// ===== verif/duplicate_value_finder_tb.sv =====
// Testbench for the duplicate value finder: directed and random lists checked against a search predictor.
`timescale 1ns / 100ps

module duplicate_value_finder_tb;

  localparam int RandRequests = 1600;
  localparam int CycleLimit   = 1_000_000;
  localparam int IdlePct      = 28;

  // Mirrors the list store and works out the search verdict on each final request.
  class dup_scoreboard;
    logic [dvf_pkg::ValInW-1:0] stored [dvf_pkg::MaxElements];
    int                         fill = 0;
    bit                         bad_seen = 1'b0;
    bit                         full_seen = 1'b0;
    dvf_pkg::out_t              verdict_q [$];
    int                         mismatches = 0;

    function void note_request(dvf_pkg::in_t req);
      dvf_pkg::out_t want;
      int            n;
      int            lo;
      int            hi;
      int            mid;
      int            hits;
      bit            done;
      if (fill == dvf_pkg::MaxElements) begin
        full_seen = 1'b1;
      end else begin
        // out-of-range values still take a slot
        if (req.value == 0 || req.value >= dvf_pkg::MaxElements) begin
          bad_seen = 1'b1;
          stored[fill] = '0;
        end else begin
          stored[fill] = req.value;
        end
        fill++;
      end
      if (!req.is_last) return;

      want.status    = dvf_pkg::StNone;
      want.duplicate = '0;
      if (full_seen) begin
        want.status = dvf_pkg::StOverflow;
      end else if (bad_seen || fill < 2) begin
        want.status = dvf_pkg::StRange;
      end else begin
        n = fill - 1;
        for (int i = 0; i < fill; i++) begin
          if (stored[i] > n) want.status = dvf_pkg::StRange;
        end
        if (want.status != dvf_pkg::StRange) begin
          lo   = 1;
          hi   = n;
          done = 1'b0;
          while (!done && lo <= hi) begin
            mid  = (lo + hi) / 2;
            hits = 0;
            for (int i = 0; i < fill; i++) begin
              if (stored[i] >= lo && stored[i] <= mid) hits++;
            end
            if (lo == hi) begin
              if (hits > 1) begin
                want.status    = dvf_pkg::StFound;
                want.duplicate = dvf_pkg::DupW'(lo);
              end
              done = 1'b1;
            end else if (hits > mid - lo + 1) begin
              hi = mid;
            end else begin
              lo = mid + 1;
            end
          end
        end
      end
      verdict_q.push_back(want);

      // start the next list
      fill      = 0;
      bad_seen  = 1'b0;
      full_seen = 1'b0;
    endfunction

    function void check_result(dvf_pkg::out_t got);
      dvf_pkg::out_t want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d duplicate %0d", got.status, got.duplicate);
      end else begin
        want = verdict_q.pop_front();
        if (got.status !== want.status || got.duplicate !== want.duplicate) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result wrong: expected status %0d duplicate %0d, ",
                      "got status %0d duplicate %0d"},
                     want.status, want.duplicate, got.status, got.duplicate);
        end
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          req_valid = 1'b0;
  logic          req_stall;
  dvf_pkg::in_t  req_data = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  dvf_pkg::out_t res_data;

  dup_scoreboard              sb;
  logic [dvf_pkg::ValInW-1:0] list_q [$];
  bit                         calm = 1'b0;
  int                         requests_sent = 0;
  int                         cycles = 0;

  duplicate_value_finder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
  end

  always @(posedge clk) begin
    cycles++;
    if (req_valid && !req_stall) sb.note_request(req_data);
    if (res_valid && !res_stall) sb.check_result(res_data);
    if (cycles == CycleLimit) begin
      $display("duplicate_value_finder: mismatch");
      $finish;
    end
  end

  // Hold the request until accepted; drop valid for a random run of cycles first.
  task automatic send_request(input logic [dvf_pkg::ValInW-1:0] value, input logic last);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_data  <= '{value: value, is_last: last};
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_list();
    for (int i = 0; i < list_q.size(); i++) send_request(list_q[i], i == list_q.size() - 1);
  endtask

  // Drop valid and wait until every pending verdict has been returned.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.verdict_q.size() != 0);
  endtask

  initial begin
    int                         n;
    int                         pick;
    int                         pos;
    int                         lists;
    logic [dvf_pkg::ValInW-1:0] swap;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single element: nothing can be in range
    list_q = '{16'd1};
    send_list();
    list_q = '{16'd1, 16'd1};
    send_list();
    list_q = '{16'd0, 16'd1};
    send_list();
    list_q = '{16'd2, 16'd1, 16'd2};
    send_list();
    list_q = '{16'd1, 16'd256, 16'd1};
    send_list();
    list_q = '{16'hFFFF, 16'd1, 16'd1};
    send_list();
    // storable but above the list's own range
    list_q = '{16'd255, 16'd1, 16'd1};
    send_list();
    list_q = '{16'd3, 16'd3, 16'd3, 16'd3};
    send_list();
    list_q = '{16'h5555, 16'hAAAA};
    send_list();
    drain();

    requests_sent = 0;
    lists = 0;
    while (requests_sent < RandRequests) begin
      lists++;
      calm = (lists >= 30 && lists < 55);
      pick = $urandom_range(0, 99);
      list_q.delete();
      if (lists == 10) begin
        // full store: every value once, the top value twice, shuffled
        for (int v = 1; v < dvf_pkg::MaxElements; v++) list_q.push_back(dvf_pkg::ValInW'(v));
        list_q.push_back(dvf_pkg::ValInW'(dvf_pkg::MaxElements - 1));
        for (int i = list_q.size() - 1; i > 0; i--) begin
          pos        = $urandom_range(0, i);
          swap       = list_q[i];
          list_q[i]  = list_q[pos];
          list_q[pos] = swap;
        end
      end else if (lists == 20) begin
        // overrun the store, with a zero inside as well
        n = dvf_pkg::MaxElements + $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          list_q.push_back(dvf_pkg::ValInW'($urandom_range(1, dvf_pkg::MaxElements - 1)));
        list_q[$urandom_range(0, dvf_pkg::MaxElements - 1)] = '0;
      end else begin
        n = (pick < 10) ? $urandom_range(16, 63) : $urandom_range(1, 15);
        for (int i = 0; i <= n; i++) list_q.push_back(dvf_pkg::ValInW'($urandom_range(1, n)));
        if (pick >= 70 && pick < 85) begin
          pos = $urandom_range(0, n);
          case ($urandom_range(0, 3))
            0: begin
              list_q[pos] = '0;
            end
            1: begin
              list_q[pos] = dvf_pkg::ValInW'($urandom_range(n + 1, dvf_pkg::MaxElements - 1));
            end
            2: begin
              list_q[pos] = dvf_pkg::ValInW'($urandom_range(dvf_pkg::MaxElements, 65535));
            end
            default: begin
              list_q[pos] = dvf_pkg::ValInW'($urandom());
            end
          endcase
        end else if (pick >= 85) begin
          list_q.delete();
          repeat ($urandom_range(1, 6)) list_q.push_back(dvf_pkg::ValInW'($urandom()));
        end
      end
      send_list();
      if ($urandom_range(0, 99) < 5) drain();
    end

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("duplicate_value_finder: match");
    end else begin
      $display("duplicate_value_finder: mismatch");
    end
    $finish;
  end

endmodule
